[rtl/hrl_pkg.sv]
package hrl_pkg;

   // Fixed point: hue fraction, lightness and channel values are unsigned Q0.16.
   localparam int unsigned NUM_STAGES = 7;

   localparam logic [16:0] ONE_Q16   = 17'd65536;
   localparam logic [15:0] THIRD_Q16 = 16'd21845;

   localparam logic [15:0] OFF_CODE_DEFAULT = 16'hFFFF;
   localparam logic [8:0]  HUE_MAX          = 9'd359;

   // floor(2^32 / 360): hue times this, shifted down by 16, undershoots by at most one.
   localparam logic [23:0] HUE_RECIP = 24'd11930464;
   // 65793 / 2^24 sits just below 1/255, so one correction step is enough.
   localparam logic [16:0] RECIP_255 = 17'd65793;

   // Register indexes of the configuration port.
   localparam logic [0:0] CSR_BRIGHTNESS = 1'b0;
   localparam logic [0:0] CSR_SATURATION = 1'b1;

   typedef enum logic [1:0] {
      SEG_RAMP = 2'b00,
      SEG_HIGH = 2'b01,
      SEG_LOW  = 2'b10
   } seg_sel_type;

   // Load enables of the stages that live inside the channel slices.
   typedef struct packed {
      logic s4;
      logic s5;
      logic s6;
      logic s7;
   } hrl_stage_en_type;

   typedef logic [15:0] l16_table_type [128];

   function automatic l16_table_type build_l16_table();
      l16_table_type tbl;
      for (int i = 0; i < 128; i++) begin
         tbl[i] = 16'((i * 65536) / 200);
      end
      return tbl;
   endfunction

   // Lightness in Q0.16 for each brightness percent code.
   localparam l16_table_type L16_TABLE = build_l16_table();

   // floor(v * 255 / 65536) for v up to 1.0; never exceeds 255.
   function automatic logic [7:0] to_level(input logic [16:0] v);
      logic [24:0] x;
      x = {v, 8'b0} - {8'b0, v};
      return x[23:16];
   endfunction

endpackage

[rtl/hrl_channel.sv]
module hrl_channel
   import hrl_pkg::*;
(
   input  logic             clock,
   input  hrl_stage_en_type stage_en,
   input  logic [15:0]      s3_t,
   input  logic [16:0]      s4_p,
   input  logic [16:0]      s4_q,
   input  logic [16:0]      s5_p,
   input  logic [16:0]      s5_q,
   input  logic             s6_force,
   input  logic [7:0]       s6_force_level,
   output logic [7:0]       level
);

   logic [18:0]  six_t;
   logic [17:0]  three_t;
   seg_sel_type  s4_sel_in, s4_sel_ff;
   logic [16:0]  s4_f_in, s4_f_ff;

   logic [16:0]  diff;
   logic [33:0]  prod;
   seg_sel_type  s5_sel_ff;
   logic [16:0]  s5_ramp_in, s5_ramp_ff;

   logic [16:0]  s6_seg_in, s6_seg_ff;
   logic [7:0]   s7_level_in, s7_level_ff;

   // Pick the segment of the hue circle: rising ramp, top, falling ramp or bottom.
   always_comb begin
      six_t   = {1'b0, s3_t, 2'b0} + {2'b0, s3_t, 1'b0};
      three_t = {1'b0, s3_t, 1'b0} + {2'b0, s3_t};
      if (six_t < 19'd65536) begin
         s4_sel_in = SEG_RAMP;
         s4_f_in   = six_t[16:0];
      end else if (s3_t < 16'd32768) begin
         s4_sel_in = SEG_HIGH;
         s4_f_in   = '0;
      end else if (three_t < 18'd131072) begin
         s4_sel_in = SEG_RAMP;
         s4_f_in   = 17'(19'd262144 - six_t);
      end else begin
         s4_sel_in = SEG_LOW;
         s4_f_in   = '0;
      end
   end

   always_comb begin
      diff       = s4_q - s4_p;
      prod       = 34'(diff) * 34'(s4_f_ff);
      s5_ramp_in = prod[32:16];
   end

   always_comb begin
      case (s5_sel_ff)
         SEG_RAMP: s6_seg_in = s5_p + s5_ramp_ff;
         SEG_HIGH: s6_seg_in = s5_q;
         SEG_LOW:  s6_seg_in = s5_p;
         default:  s6_seg_in = s5_p;
      endcase
   end

   assign s7_level_in = s6_force ? s6_force_level : to_level(s6_seg_ff);

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         s4_sel_ff <= s4_sel_in;
         s4_f_ff   <= s4_f_in;
      end
      if (stage_en.s5) begin
         s5_sel_ff  <= s4_sel_ff;
         s5_ramp_ff <= s5_ramp_in;
      end
      if (stage_en.s6) begin
         s6_seg_ff <= s6_seg_in;
      end
      if (stage_en.s7) begin
         s7_level_ff <= s7_level_in;
      end
   end

   assign level = s7_level_ff;

endmodule

[rtl/hue_to_rgb_led_color.sv]
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------------------
// req      | in        | req_tvalid/req_tready  | req_tdata: hue in degrees
// rsp      | out       | rsp_tvalid/rsp_tready  | rsp_tdata: red, green, blue levels
// csr      | in        | csr_valid/csr_ready    | csr_index, csr_data: register write
//
// The converter is a seven stage pipeline and takes one hue transaction in every cycle
// while rsp is not stalled; a result passes the hue scaling, the divide by 255 and the
// segment multiply on its way to rsp. Each stage holds while it is full and the stage
// after it cannot take its item, so a stalled output holds its result while empty stages
// upstream keep filling. Synchronous reset empties the pipeline and restores brightness 0
// and saturation 255. The csr port is always ready; the user must write registers only
// while no transaction is in flight, which the block itself does not enforce.
module hue_to_rgb_led_color
   import hrl_pkg::*;
#(
   parameter logic [15:0] OFF_CODE = OFF_CODE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] hue_degrees

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] red_level, [15:8] green_level, [23:16] blue_level

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // Configuration registers.
   logic [6:0] brightness_ff, brightness_in;
   logic [7:0] saturation_ff, saturation_in;

   // Valid bits of the stages and their load enables; stage_en[7] is the output side.
   logic [NUM_STAGES-1:0] stage_valid_ff, stage_valid_in;
   logic [NUM_STAGES:0]   stage_en;
   hrl_stage_en_type      chan_en;

   // Stage 1: clamp the hue, look up lightness, first estimate of the hue fraction.
   logic        s1_off_in, s1_off_ff;
   logic [8:0]  s1_hue_in, s1_hue_ff;
   logic [15:0] s1_l16_in, s1_l16_ff;
   logic [32:0] hue_prod;
   logic [15:0] s1_hest_in, s1_hest_ff;

   // Stage 2: exact hue fraction, numerator of the saturation term, grey detection.
   logic [25:0] hue_lhs;
   logic [25:0] hue_est360;
   logic [16:0] l16_comp;
   logic        s2_off_ff;
   logic [15:0] s2_h16_in, s2_h16_ff;
   logic [23:0] s2_qnum_in, s2_qnum_ff;
   logic        s2_grey_in, s2_grey_ff;
   logic [7:0]  s2_grey_lvl_in, s2_grey_lvl_ff;
   logic [15:0] s2_l16_ff;

   // Stage 3: hue positions of the three channels, estimate of the divide by 255.
   logic [40:0] qnum_prod;
   logic [15:0] s3_tr_in, s3_tr_ff;
   logic [15:0] s3_tg_ff;
   logic [15:0] s3_tb_in, s3_tb_ff;
   logic [16:0] s3_qest_in, s3_qest_ff;
   logic [23:0] s3_qnum_ff;
   logic [15:0] s3_l16_ff;
   logic        s3_off_ff, s3_grey_ff;
   logic [7:0]  s3_grey_lvl_ff;

   // Stage 4: corrected quotient, then the upper and lower bounds Q and P.
   logic [25:0] qest255;
   logic [16:0] qdiv;
   logic [17:0] p_wide;
   logic [16:0] s4_q_in, s4_q_ff;
   logic [16:0] s4_p_in, s4_p_ff;
   logic        s4_off_ff, s4_grey_ff;
   logic [7:0]  s4_grey_lvl_ff;

   // Stages 5 and 6 carry the bounds and the override flags beside the channel slices.
   logic [16:0] s5_q_ff, s5_p_ff;
   logic        s5_off_ff, s5_grey_ff;
   logic [7:0]  s5_grey_lvl_ff;
   logic        s6_off_ff, s6_grey_ff;
   logic [7:0]  s6_grey_lvl_ff;
   logic        s6_force;
   logic [7:0]  s6_force_level;

   logic [7:0]  red_level, green_level, blue_level;

   // ---------------------------------------------------------------------------------------
   // Configuration port. Writes to an index outside the list are taken and ignored.
   // ---------------------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      brightness_in = brightness_ff;
      saturation_in = saturation_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BRIGHTNESS: brightness_in = csr_data[6:0];
            CSR_SATURATION: saturation_in = csr_data;
            default: begin
               brightness_in = brightness_ff;
               saturation_in = saturation_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= 7'd0;
         saturation_ff <= 8'd255;
      end else begin
         brightness_ff <= brightness_in;
         saturation_ff <= saturation_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or when its item moves on,
   // so bubbles close up behind a stalled output.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      stage_en[7] = rsp_tready;
      stage_en[6] = !stage_valid_ff[6] || stage_en[7];
      stage_en[5] = !stage_valid_ff[5] || stage_en[6];
      stage_en[4] = !stage_valid_ff[4] || stage_en[5];
      stage_en[3] = !stage_valid_ff[3] || stage_en[4];
      stage_en[2] = !stage_valid_ff[2] || stage_en[3];
      stage_en[1] = !stage_valid_ff[1] || stage_en[2];
      stage_en[0] = !stage_valid_ff[0] || stage_en[1];
   end

   always_comb begin
      stage_valid_in[0] = stage_en[0] ? req_tvalid        : stage_valid_ff[0];
      stage_valid_in[1] = stage_en[1] ? stage_valid_ff[0] : stage_valid_ff[1];
      stage_valid_in[2] = stage_en[2] ? stage_valid_ff[1] : stage_valid_ff[2];
      stage_valid_in[3] = stage_en[3] ? stage_valid_ff[2] : stage_valid_ff[3];
      stage_valid_in[4] = stage_en[4] ? stage_valid_ff[3] : stage_valid_ff[4];
      stage_valid_in[5] = stage_en[5] ? stage_valid_ff[4] : stage_valid_ff[5];
      stage_valid_in[6] = stage_en[6] ? stage_valid_ff[5] : stage_valid_ff[6];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = stage_valid_ff[6];

   assign chan_en.s4 = stage_en[3];
   assign chan_en.s5 = stage_en[4];
   assign chan_en.s6 = stage_en[5];
   assign chan_en.s7 = stage_en[6];

   // ---------------------------------------------------------------------------------------
   // Stage 1. Hues above 359 clamp, the off code is flagged and later forces black.
   // The hue fraction estimate hue * 2^16 / 360 may be one short; stage 2 corrects it.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      s1_off_in  = (req_tdata == OFF_CODE);
      s1_hue_in  = (req_tdata > 16'(HUE_MAX)) ? HUE_MAX : req_tdata[8:0];
      s1_l16_in  = L16_TABLE[brightness_ff];
      hue_prod   = 33'(s1_hue_in) * 33'(HUE_RECIP);
      s1_hest_in = hue_prod[31:16];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_off_ff  <= s1_off_in;
         s1_hue_ff  <= s1_hue_in;
         s1_l16_ff  <= s1_l16_in;
         s1_hest_ff <= s1_hest_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 2. The estimate is raised by one when the remainder still holds a whole 360.
   // The saturation term numerator depends on which half lightness lies in. Zero
   // saturation or zero lightness gives a grey at level L.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      hue_lhs    = {1'b0, s1_hue_ff, 16'b0};
      hue_est360 = {2'b0, s1_hest_ff, 8'b0} + {4'b0, s1_hest_ff, 6'b0}
                 + {5'b0, s1_hest_ff, 5'b0} + {7'b0, s1_hest_ff, 3'b0};
      s2_h16_in  = s1_hest_ff + 16'(hue_lhs >= hue_est360 + 26'd360);

      l16_comp = ONE_Q16 - {1'b0, s1_l16_ff};
      if (!s1_l16_ff[15]) begin
         s2_qnum_in = 24'(s1_l16_ff) * 24'(saturation_ff);
      end else begin
         s2_qnum_in = 24'(l16_comp[15:0]) * 24'(saturation_ff);
      end

      s2_grey_in     = (saturation_ff == 8'd0) || (s1_l16_ff == 16'd0);
      s2_grey_lvl_in = to_level({1'b0, s1_l16_ff});
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_off_ff      <= s1_off_ff;
         s2_h16_ff      <= s2_h16_in;
         s2_qnum_ff     <= s2_qnum_in;
         s2_grey_ff     <= s2_grey_in;
         s2_grey_lvl_ff <= s2_grey_lvl_in;
         s2_l16_ff      <= s1_l16_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 3. Red sits a third of the circle ahead of green and blue a third behind; the
   // sums wrap modulo one, so a position of exactly one reads as zero.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      s3_tr_in   = s2_h16_ff + THIRD_Q16;
      s3_tb_in   = s2_h16_ff - THIRD_Q16;
      qnum_prod  = 41'(s2_qnum_ff) * 41'(RECIP_255);
      s3_qest_in = qnum_prod[40:24];
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_tr_ff       <= s3_tr_in;
         s3_tg_ff       <= s2_h16_ff;
         s3_tb_ff       <= s3_tb_in;
         s3_qest_ff     <= s3_qest_in;
         s3_qnum_ff     <= s2_qnum_ff;
         s3_l16_ff      <= s2_l16_ff;
         s3_off_ff      <= s2_off_ff;
         s3_grey_ff     <= s2_grey_ff;
         s3_grey_lvl_ff <= s2_grey_lvl_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 4. Finish the divide by 255, then Q = L + term and P = 2L - Q.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      qest255 = {1'b0, s3_qest_ff, 8'b0} - {9'b0, s3_qest_ff};
      qdiv    = s3_qest_ff + 17'(26'(s3_qnum_ff) >= qest255 + 26'd255);
      s4_q_in = {1'b0, s3_l16_ff} + qdiv;
      p_wide  = {1'b0, s3_l16_ff, 1'b0} - {1'b0, s4_q_in};
      s4_p_in = p_wide[16:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_q_ff        <= s4_q_in;
         s4_p_ff        <= s4_p_in;
         s4_off_ff      <= s3_off_ff;
         s4_grey_ff     <= s3_grey_ff;
         s4_grey_lvl_ff <= s3_grey_lvl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s5_q_ff        <= s4_q_ff;
         s5_p_ff        <= s4_p_ff;
         s5_off_ff      <= s4_off_ff;
         s5_grey_ff     <= s4_grey_ff;
         s5_grey_lvl_ff <= s4_grey_lvl_ff;
      end
      if (stage_en[5]) begin
         s6_off_ff      <= s5_off_ff;
         s6_grey_ff     <= s5_grey_ff;
         s6_grey_lvl_ff <= s5_grey_lvl_ff;
      end
   end

   // The off code wins over grey; either replaces the computed level in the last stage.
   assign s6_force       = s6_off_ff || s6_grey_ff;
   assign s6_force_level = s6_off_ff ? 8'd0 : s6_grey_lvl_ff;

   // ---------------------------------------------------------------------------------------
   // Channel slices: segment choice, ramp multiply, segment value and scaling to 8 bits.
   // ---------------------------------------------------------------------------------------
   hrl_channel u_red (
      .clock          (clock),
      .stage_en       (chan_en),
      .s3_t           (s3_tr_ff),
      .s4_p           (s4_p_ff),
      .s4_q           (s4_q_ff),
      .s5_p           (s5_p_ff),
      .s5_q           (s5_q_ff),
      .s6_force       (s6_force),
      .s6_force_level (s6_force_level),
      .level          (red_level)
   );

   hrl_channel u_green (
      .clock          (clock),
      .stage_en       (chan_en),
      .s3_t           (s3_tg_ff),
      .s4_p           (s4_p_ff),
      .s4_q           (s4_q_ff),
      .s5_p           (s5_p_ff),
      .s5_q           (s5_q_ff),
      .s6_force       (s6_force),
      .s6_force_level (s6_force_level),
      .level          (green_level)
   );

   hrl_channel u_blue (
      .clock          (clock),
      .stage_en       (chan_en),
      .s3_t           (s3_tb_ff),
      .s4_p           (s4_p_ff),
      .s4_q           (s4_q_ff),
      .s5_p           (s5_p_ff),
      .s5_q           (s5_q_ff),
      .s6_force       (s6_force),
      .s6_force_level (s6_force_level),
      .level          (blue_level)
   );

   assign rsp_tdata = {blue_level, green_level, red_level};

   // ---------------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------------

   // The cycle after reset the pipeline holds no transaction.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> stage_valid_ff == '0)
      else $error("pipeline not empty after reset");

   // The bounds of a coloured item satisfy P <= Q <= 1.0.
   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[3] && !s4_grey_ff |-> (s4_p_ff <= s4_q_ff) && (s4_q_ff <= ONE_Q16))
      else $error("colour bounds out of order");

   // An off-code transaction moving into the output register comes out black.
   a_off_is_black: assert property (@(posedge clock) disable iff (reset)
      stage_en[6] && stage_valid_ff[5] && s6_off_ff |=> rsp_tdata == 24'd0)
      else $error("off code did not give black");

endmodule

[tb/testbench.sv]
module testbench
   import hrl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any transaction on any channel before the run is declared hung.
   // The longest legitimate quiet spell is the deliberate receiver hold-off, which is
   // far shorter than this.
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   // Length of the deliberate receiver hold-off, in cycles.
   localparam int unsigned LONG_HOLD = 200;
   // Cycles allowed for the pipeline to settle before a register write and at the end.
   localparam int unsigned SETTLE_CYCLES = NUM_STAGES + 4;
   // Hues per random phase; ten phases give roughly 1050 hues in all.
   localparam int unsigned PHASE_HUES = 105;
   localparam int unsigned NUM_PHASES = 10;

   // One third of a turn in Q0.16, used to offset the red and blue hue positions.
   localparam longint unsigned HUE_THIRD = 21845;
   localparam longint unsigned Q16_ONE = 65536;

   // The result word, red in the lowest byte.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } led_rgb_type;

   // An expected colour, kept with the hue that produced it for the mismatch report.
   typedef struct {
      logic [15:0] hue;
      led_rgb_type colour;
   } colour_due_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [15:0] hue_degrees

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [7:0] red_level, [15:8] green_level, [23:16] blue_level

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CSR_BRIGHTNESS;
   logic [7:0]  csr_data = '0;

   // Hues waiting to be offered, filled by the sequencing block below.
   logic [15:0] hue_backlog [$];
   // Colours predicted for accepted hues that have not yet come out of the block.
   colour_due_type colour_due [$];

   // The predictor's copy of the two registers, starting from their reset values.
   logic [6:0]  bright_reg = 7'd0;
   logic [7:0]  sat_reg = 8'd255;

   // Idling controls, percent of cycles in which each side holds back.
   int unsigned tx_idle_pct = 0;
   int unsigned rx_stall_pct = 0;

   // The sequencing block asks for a long receiver hold-off by bumping hold_requests;
   // the receiver process serves each request once.
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;

   int unsigned fault_count = 0;
   int unsigned quiet_cycles = 0;

   hue_to_rgb_led_color dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Colour predictor. All values are Q0.16 held in wide unsigned integers, and every
   // division truncates, exactly as the block is specified to.
   // ---------------------------------------------------------------------------------

   // Scale a Q0.16 channel value to an 8-bit level, truncating.
   function automatic logic [7:0] q16_to_level(input longint unsigned v);
      longint unsigned scaled;
      scaled = (v * 255) >> 16;
      return (scaled > 255) ? 8'd255 : scaled[7:0];
   endfunction

   // Channel value at hue position t of the piecewise HSL curve between lo and hi:
   // rising over the first sixth, flat high to one half, falling to two thirds, then low.
   function automatic longint unsigned hsl_curve(input longint unsigned lo,
                                                  input longint unsigned hi,
                                                  input longint unsigned t);
      longint unsigned span;
      span = hi - lo;
      if (t * 6 < Q16_ONE) begin
         return lo + ((span * (t * 6)) >> 16);
      end
      if (t < 32768) begin
         return hi;
      end
      if (t * 3 < 131072) begin
         return lo + ((span * (262144 - t * 6)) >> 16);
      end
      return lo;
   endfunction

   function automatic led_rgb_type predict_colour(input logic [15:0] hue_in,
                                                  input logic [6:0]  bright,
                                                  input logic [7:0]  sat);
      longint unsigned hue, light, satn, frac, hi, lo;
      led_rgb_type     c;
      logic [7:0]      grey;
      // The off code turns every channel off, whatever the registers hold.
      if (hue_in == OFF_CODE_DEFAULT) begin
         return '0;
      end
      hue = (hue_in > HUE_MAX) ? HUE_MAX : hue_in;
      satn = sat;
      light = bright;
      light = (light * Q16_ONE) / 200;
      if (satn == 0 || light == 0) begin
         // No saturation or no lightness: a grey at the lightness level.
         grey = q16_to_level(light);
         c.red = grey;
         c.green = grey;
         c.blue = grey;
      end else begin
         frac = (hue * Q16_ONE) / 360;
         if (light < 32768) begin
            hi = light + (light * satn) / 255;
         end else begin
            hi = light + (satn * (Q16_ONE - light)) / 255;
         end
         lo = 2 * light - hi;
         c.red   = q16_to_level(hsl_curve(lo, hi, (frac + HUE_THIRD) & 16'hFFFF));
         c.green = q16_to_level(hsl_curve(lo, hi, frac));
         c.blue  = q16_to_level(hsl_curve(lo, hi, (frac + Q16_ONE - HUE_THIRD) & 16'hFFFF));
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------------------
   // Driver. It offers hues from the backlog, holding each one until it is taken, and
   // records the predicted colour for every hue transaction at the edge it is accepted.
   // The registers cannot change while a hue is in flight, so the predictor's copy of
   // them is the one the block uses for that hue.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            colour_due.push_back('{hue: req_tdata,
                                   colour: predict_colour(req_tdata, bright_reg, sat_reg)});
         end
         if (!req_tvalid || req_tready) begin
            if (hue_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= hue_backlog.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver. It stalls at random, and on request holds rsp_tready low for a long
   // stretch so that the pipeline fills up and pushes back on the hue channel.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_tready <= 1'b0;
         hold_served <= hold_served + 1;
         hold_left <= LONG_HOLD - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------------
   // Monitor. Every colour transaction is checked, field by field, against the oldest
   // outstanding prediction.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      colour_due_type want;
      led_rgb_type    got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (colour_due.size() == 0) begin
            fault_count++;
            $display("%0t: colour r=%0d g=%0d b=%0d arrived with none expected",
                     $time, got.red, got.green, got.blue);
         end else begin
            want = colour_due.pop_front();
            if (got.red !== want.colour.red || got.green !== want.colour.green ||
                got.blue !== want.colour.blue) begin
               fault_count++;
               $display("%0t: hue %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        $time, want.hue, want.colour.red, want.colour.green,
                        want.colour.blue, got.red, got.green, got.blue);
            end
         end
      end
   end

   // Watchdog: any transaction on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("hue_to_rgb_led_color regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencing. Checks of the testbench's own queues are made at the falling edge, when
   // the clocked processes above have all settled, so nothing here races with them.
   // ---------------------------------------------------------------------------------

   // Wait until every hue has been offered and taken and every colour has come back,
   // then give the pipeline time to go quiet.
   task automatic wait_drained();
      do @(negedge clock);
      while (hue_backlog.size() != 0 || req_tvalid || colour_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write transaction; the predictor's copy follows at the accepting edge.
   task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_BRIGHTNESS) begin
         bright_reg = value[6:0];
      end else begin
         sat_reg = value;
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly hues in the normal range, with some out of range, some off codes and some
   // fully random words so that every bit of the field toggles.
   function automatic logic [15:0] random_hue();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 78) return 16'($urandom_range(359));
      if (roll < 88) return 16'($urandom_range(65534, 360));
      if (roll < 93) return OFF_CODE_DEFAULT;
      return 16'($urandom);
   endfunction

   initial begin
      logic [15:0] directed_hues [$];
      logic [7:0]  bright_val, sat_val;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // A few hues at the reset settings: zero lightness gives black, and the off code.
      @(negedge clock);
      hue_backlog.push_back(16'd0);
      hue_backlog.push_back(16'd200);
      hue_backlog.push_back(OFF_CODE_DEFAULT);
      wait_drained();

      // Directed hues at half lightness and full saturation: segment boundaries, the
      // primaries and secondaries, the clamp above 359 and the off code.
      write_reg(CSR_BRIGHTNESS, 8'd100);
      write_reg(CSR_SATURATION, 8'd255);
      directed_hues = '{16'd0, 16'd1, 16'd30, 16'd59, 16'd60, 16'd61, 16'd119, 16'd120,
                        16'd180, 16'd239, 16'd240, 16'd300, 16'd359, 16'd360, 16'd361,
                        16'd1000, 16'h8000, 16'h5555, 16'h2AAA, 16'hFFFE, OFF_CODE_DEFAULT};
      @(negedge clock);
      foreach (directed_hues[i]) begin
         hue_backlog.push_back(directed_hues[i]);
      end
      wait_drained();

      // Random phases. The first few use fixed settings that reach the extremes: full
      // and over-range brightness, zero saturation and zero lightness (both grey), and
      // the smallest non-zero values. Later phases pick both registers at random.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin
               bright_val = 8'd100;
               sat_val = 8'd255;
            end
            1: begin
               bright_val = 8'd127;
               sat_val = 8'd200;
            end
            2: begin
               // The top bit of the data lies outside the 7-bit brightness register.
               bright_val = 8'd165;
               sat_val = 8'd0;
            end
            3: begin
               bright_val = 8'd0;
               sat_val = 8'd128;
            end
            4: begin
               bright_val = 8'd1;
               sat_val = 8'd1;
            end
            5: begin
               bright_val = 8'd99;
               sat_val = 8'd254;
            end
            default: begin
               bright_val = 8'($urandom_range(255));
               sat_val = 8'($urandom_range(255));
            end
         endcase
         write_reg(CSR_BRIGHTNESS, bright_val);
         write_reg(CSR_SATURATION, sat_val);

         // Idling cycles through: none, sender idle, receiver stalling, both.
         @(negedge clock);
         case (p % 4)
            0: begin
               tx_idle_pct = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct = 69;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct = 0;
               rx_stall_pct = 69;
            end
            default: begin
               tx_idle_pct = 27;
               rx_stall_pct = 27;
            end
         endcase

         // With the sender never idle, a long receiver hold-off backs the pipeline up
         // until the hue channel stalls.
         if (p == 0 || p == 8) begin
            hold_requests++;
         end

         if (p == 5) begin
            // The sender stops half way and waits for every colour before resuming.
            for (int i = 0; i < PHASE_HUES / 2; i++) begin
               hue_backlog.push_back(random_hue());
            end
            wait_drained();
            for (int i = PHASE_HUES / 2; i < PHASE_HUES; i++) begin
               hue_backlog.push_back(random_hue());
            end
         end else begin
            for (int i = 0; i < PHASE_HUES; i++) begin
               hue_backlog.push_back(random_hue());
            end
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (colour_due.size() != 0) begin
         fault_count++;
         $display("%0t: %0d colours never arrived", $time, colour_due.size());
      end
      if (fault_count == 0) begin
         $display("hue_to_rgb_led_color regression: pass");
      end else begin
         $display("hue_to_rgb_led_color regression: fail");
      end
      $finish;
   end

endmodule
